// ===== sv/bpa_pkg.sv =====
package bpa_pkg;
   localparam int MaxOrder = 6;
   localparam int MaxPages = 256;
   localparam int PageW = 8;
   localparam int LinkW = 9;
   localparam int CntW = 9;
   localparam int TakenDepth = 2 * MaxPages;
   localparam int TakenAw = 9;
   localparam int OrdW = 3;
   localparam logic [LinkW-1:0] NilLink = LinkW'(MaxPages);
   localparam logic FuncAlloc = 1'b0;
   localparam logic FuncFree = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_A_SCAN,
      ST_A_POPRD,
      ST_A_POPWT,
      ST_A_SPLIT,
      ST_F_START,
      ST_F_BRD,
      ST_F_BWT,
      ST_F_WALK,
      ST_F_WWT,
      ST_F_WCHK,
      ST_F_CRD,
      ST_F_CWT,
      ST_F_UNL,
      ST_F_MERGE,
      ST_F_PUSH,
      ST_DONE
   } state_type;

   // bit offset of order k in the taken memory
   function automatic logic [TakenAw-1:0] taken_addr(input logic [OrdW-1:0] k,
                                                     input logic [PageW-1:0] pg);
      logic [TakenAw:0] base;
      base = (TakenAw+1)'(TakenDepth) - ((TakenAw+1)'(TakenDepth) >> k);
      return TakenAw'(base + (TakenAw+1)'(pg >> k));
   endfunction
endpackage

// ===== sv/bpa_ram.sv =====
module bpa_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== sv/buddy_page_allocator.sv =====
// channel | direction | tdata (low bit first)               | notes
// req     | in        | func[0], order[3:1], page[11:4]       | one transaction per operation
// rsp     | out       | ok[0], alloc_page[8:1], free_count[17:9] | one per request
// csr     | in        | window_pages[8:0]                     | write only
// an allocate scans the free lists up from the requested order and splits the block popped,
// a miss ends after the scan; a free merges level by level while the buddy is free,
// walking the free list of that order to unlink the buddy, with wait states
// set by the registered reads of the taken and link memories.
// after reset the taken memory is swept to all ones, no request taken until the sweep ends.
// the result is held in an output register; a stalled rsp holds the block.
module buddy_page_allocator
   import bpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // func, order, page
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // ok, alloc_page, free_count
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata    // window_pages
);
   state_type state_ff, state_in;
   logic [8:0] win_ff, win_in;
   logic [LinkW-1:0] heads_ff [MaxOrder+1];
   logic [LinkW-1:0] heads_in [MaxOrder+1];
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [TakenAw:0] clr_ff, clr_in;
   logic [OrdW-1:0] ord_ff, ord_in, k_ff, k_in;
   logic [PageW-1:0] pg_ff, pg_in;
   logic [LinkW-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [LinkW-1:0] steps_ff, steps_in;
   logic ok_ff, ok_in;
   logic [PageW-1:0] rpage_ff, rpage_in;
   logic [CntW-1:0] rcnt_ff, rcnt_in;

   logic t_we, t_wd, t_rd;
   logic [TakenAw-1:0] t_wa, t_ra;
   logic l_we;
   logic [PageW-1:0] l_wa, l_ra;
   logic [LinkW-1:0] l_wd, l_rd;

   bpa_ram #(.Width(1), .Depth(TakenDepth)) u_taken (
      .clock, .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd), .rd_addr(t_ra), .rd_data(t_rd));
   bpa_ram #(.Width(LinkW), .Depth(MaxPages)) u_link (
      .clock, .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd), .rd_addr(l_ra), .rd_data(l_rd));

   logic [8:0] ewin;
   logic [PageW-1:0] bpg, half;
   logic [OrdW-1:0] rq_order;
   logic [8:0] size, pgal;
   logic [8:0] bidx;
   logic [8:0] wcnt;

   always_comb begin
      ewin = (win_ff > 9'(MaxPages)) ? 9'(MaxPages) : win_ff;
      ewin = ewin & ~9'((1 << MaxOrder) - 1);
      bpg = pg_ff ^ PageW'(9'd1 << k_ff);
      half = pg_ff + PageW'(9'd1 << (k_ff - 3'd1));
      rq_order = req_tdata[3:1];
      size = 9'd1 << ord_ff;
      pgal = {1'b0, req_tdata[11:4]} & ~((9'd1 << rq_order) - 9'd1);
      bidx = 9'(pg_ff >> k_ff) ^ 9'd1;
      wcnt = ewin >> k_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         win_ff <= 9'd256;
         cnt_ff <= '0;
         clr_ff <= '0;
         for (int i = 0; i <= MaxOrder; i++) heads_ff[i] <= NilLink;
      end else begin
         state_ff <= state_in;
         win_ff <= win_in;
         cnt_ff <= cnt_in;
         clr_ff <= clr_in;
         heads_ff <= heads_in;
      end
      ord_ff <= ord_in; k_ff <= k_in; pg_ff <= pg_in;
      cur_ff <= cur_in; prev_ff <= prev_in; steps_ff <= steps_in;
      ok_ff <= ok_in; rpage_ff <= rpage_in; rcnt_ff <= rcnt_in;
   end

   always_comb begin
      state_in = state_ff;
      win_in = csr_we ? csr_wdata : win_ff;
      heads_in = heads_ff;
      cnt_in = cnt_ff;
      clr_in = clr_ff;
      ord_in = ord_ff; k_in = k_ff; pg_in = pg_ff;
      cur_in = cur_ff; prev_in = prev_ff; steps_in = steps_ff;
      ok_in = ok_ff; rpage_in = rpage_ff; rcnt_in = rcnt_ff;
      t_we = 1'b0; t_wa = taken_addr(k_ff, pg_ff); t_wd = 1'b1;
      t_ra = taken_addr(k_ff, bpg);
      l_we = 1'b0; l_wa = pg_ff; l_wd = NilLink; l_ra = cur_ff[PageW-1:0];
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!clr_ff[TakenAw]) begin
               t_we = 1'b1; t_wa = clr_ff[TakenAw-1:0]; t_wd = 1'b1;
               clr_in = clr_ff + 1'b1;
            end else begin
               req_tready = 1'b1;
               if (req_tvalid) begin
                  ord_in = rq_order; k_in = rq_order;
                  pg_in = pgal[PageW-1:0];
                  ok_in = 1'b0; rpage_in = '0; rcnt_in = cnt_ff;
                  if (32'(rq_order) > MaxOrder) state_in = ST_DONE;
                  else if (req_tdata[0] == FuncAlloc) state_in = ST_A_SCAN;
                  else if (pgal < ewin) state_in = ST_F_START;
                  else state_in = ST_DONE;
               end
            end
         end
         ST_A_SCAN: begin
            if (heads_ff[k_ff] != NilLink) state_in = ST_A_POPRD;
            else if (32'(k_ff) == MaxOrder) state_in = ST_DONE;
            else k_in = k_ff + 3'd1;
         end
         ST_A_POPRD: begin
            pg_in = heads_ff[k_ff][PageW-1:0];
            cur_in = heads_ff[k_ff];
            state_in = ST_A_POPWT;
         end
         ST_A_POPWT: begin
            // read of head link issued here, data seen in split
            l_ra = cur_ff[PageW-1:0];
            state_in = ST_A_SPLIT;
            t_we = 1'b1; t_wa = taken_addr(k_ff, pg_ff); t_wd = 1'b1;
         end
         ST_A_SPLIT: begin
            if (cur_ff == heads_ff[k_ff]) heads_in[k_ff] = l_rd;
            cur_in = NilLink;
            if (k_ff == ord_ff) begin
               ok_in = 1'b1; rpage_in = pg_ff;
               cnt_in = (cnt_ff > size) ? cnt_ff - size : '0;
               rcnt_in = (cnt_ff > size) ? cnt_ff - size : '0;
               state_in = ST_DONE;
            end else begin
               k_in = k_ff - 3'd1;
               t_we = 1'b1; t_wa = taken_addr(k_ff - 3'd1, half); t_wd = 1'b0;
               l_we = 1'b1; l_wa = half; l_wd = heads_in[k_ff - 3'd1];
               heads_in[k_ff - 3'd1] = {1'b0, half};
               state_in = ST_A_POPWT;
            end
         end
         ST_F_START: begin
            t_we = 1'b1; t_wd = 1'b0;
            state_in = ST_F_BRD;
         end
         ST_F_BRD: begin
            if (32'(k_ff) >= MaxOrder || bidx >= wcnt) state_in = ST_F_PUSH;
            else state_in = ST_F_BWT;
         end
         ST_F_BWT: begin
            if (t_rd) state_in = ST_F_PUSH;
            else begin
               cur_in = heads_ff[k_ff]; prev_in = NilLink;
               steps_in = LinkW'(MaxPages);
               state_in = ST_F_WALK;
            end
         end
         ST_F_WALK: begin
            if (cur_ff >= NilLink) state_in = ST_F_MERGE;
            else state_in = ST_F_WWT;
         end
         ST_F_WWT: state_in = ST_F_WCHK;
         ST_F_WCHK: begin
            if (cur_ff[PageW-1:0] == bpg) state_in = ST_F_UNL;
            else begin
               prev_in = cur_ff; cur_in = l_rd;
               steps_in = steps_ff - 1'b1;
               state_in = (steps_ff == '0) ? ST_F_MERGE : ST_F_WALK;
            end
         end
         ST_F_UNL: begin
            if (prev_ff == NilLink) heads_in[k_ff] = l_rd;
            else begin
               l_we = 1'b1; l_wa = prev_ff[PageW-1:0]; l_wd = l_rd;
            end
            state_in = ST_F_MERGE;
         end
         ST_F_MERGE: begin
            // mark both halves taken, lower half here and upper half next
            t_we = 1'b1; t_wa = taken_addr(k_ff, pg_ff & ~PageW'(9'd1 << k_ff)); t_wd = 1'b1;
            pg_in = pg_ff & ~PageW'(9'd1 << k_ff);
            state_in = ST_F_CRD;
         end
         ST_F_CRD: begin
            t_we = 1'b1; t_wa = taken_addr(k_ff, pg_ff | PageW'(9'd1 << k_ff)); t_wd = 1'b1;
            k_in = k_ff + 3'd1;
            state_in = ST_F_CWT;
         end
         ST_F_CWT: begin
            t_we = 1'b1; t_wd = 1'b0;
            state_in = ST_F_BRD;
         end
         ST_F_PUSH: begin
            l_we = 1'b1; l_wa = pg_ff; l_wd = heads_ff[k_ff];
            heads_in[k_ff] = {1'b0, pg_ff};
            cnt_in = ((cnt_ff + size) > 9'(MaxPages)) ? 9'(MaxPages) : cnt_ff + size;
            rcnt_in = cnt_in;
            ok_in = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tdata = {6'd0, rcnt_ff, rpage_ff, ok_ff};
endmodule

// ===== sv/bpa_checker.sv =====
module bpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp hold");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[8:1] == 8'd0) else $error("page not zero");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:9] <= 9'd256) else $error("count range");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("overlap");
endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);

// ===== tb/bpa_scoreboard.sv =====
`default_nettype none

module bpa_scoreboard
   import bpa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [8:0]  csr_wdata,
   output int               errors
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CntW-1:0]  free_count;
      logic [PageW-1:0] alloc_page;
      logic             ok;
   } alloc_result_type;

   logic             taken_map [TakenDepth];
   logic [LinkW-1:0] order_head [MaxOrder+1];
   logic [LinkW-1:0] page_link [MaxPages];
   int unsigned      pages_free;
   int unsigned      window_size;
   alloc_result_type expected_q [$];
   int               mismatches;

   function automatic void mark_block(int k, int unsigned idx, logic v);
      if (idx < (MaxPages >> k)) taken_map[TakenDepth - (TakenDepth >> k) + idx] = v;
   endfunction

   function automatic void push_block(int k, int unsigned pg);
      if (pg < MaxPages) begin
         page_link[pg] = order_head[k];
         order_head[k] = LinkW'(pg);
      end
   endfunction

   function automatic alloc_result_type run_request(logic fn, logic [OrdW-1:0] ord,
                                                    logic [PageW-1:0] pg_in);
      alloc_result_type r;
      int k;
      int unsigned pg, size, win, bi, buddy, prev, cur, steps;
      logic merging, buddy_taken, walking;
      r = '0;
      if (ord <= MaxOrder) begin
         size = 1 << ord;
         if (fn == FuncAlloc) begin
            k = ord;
            while (k <= MaxOrder && order_head[k] >= MaxPages) k++;
            if (k <= MaxOrder) begin
               pg = order_head[k];
               order_head[k] = page_link[pg];
               mark_block(k, pg >> k, 1'b1);
               while (k > ord) begin
                  k--;
                  mark_block(k, (pg + (1 << k)) >> k, 1'b0);
                  push_block(k, pg + (1 << k));
                  mark_block(k, pg >> k, 1'b1);
               end
               pages_free = (pages_free > size) ? pages_free - size : 0;
               r.ok = 1'b1;
               r.alloc_page = PageW'(pg);
            end
         end else begin
            win = (window_size > MaxPages) ? MaxPages : window_size;
            win = win & ~((1 << MaxOrder) - 1);
            pg = pg_in & ~(size - 1);
            if (pg < win) begin
               k = ord;
               mark_block(k, pg >> k, 1'b0);
               merging = 1'b1;
               while (merging && k < MaxOrder) begin
                  bi = pg >> k;
                  buddy = bi ^ 1;
                  buddy_taken = (buddy >= (MaxPages >> k)) ? 1'b1 :
                                taken_map[TakenDepth - (TakenDepth >> k) + buddy];
                  if (buddy >= (win >> k) || buddy_taken) begin
                     merging = 1'b0;
                  end else begin
                     // unlink the buddy from its list, bounded walk
                     prev = MaxPages;
                     cur = order_head[k];
                     steps = MaxPages + 1;
                     walking = 1'b1;
                     while (walking && cur < MaxPages && steps > 0) begin
                        if (cur == (buddy << k)) begin
                           if (prev == MaxPages) order_head[k] = page_link[cur];
                           else page_link[prev] = page_link[cur];
                           walking = 1'b0;
                        end else begin
                           prev = cur;
                           cur = page_link[cur];
                           steps--;
                        end
                     end
                     mark_block(k, bi, 1'b1);
                     mark_block(k, buddy, 1'b1);
                     if (buddy < bi) pg = buddy << k;
                     k++;
                     mark_block(k, pg >> k, 1'b0);
                  end
               end
               push_block(k, pg);
               pages_free = pages_free + size;
               if (pages_free > MaxPages) pages_free = MaxPages;
               r.ok = 1'b1;
            end
         end
      end
      r.free_count = CntW'(pages_free);
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type got, want;
      if (reset) begin
         foreach (taken_map[i]) taken_map[i] = 1'b1;
         foreach (order_head[i]) order_head[i] = NilLink;
         foreach (page_link[i]) page_link[i] = '0;
         pages_free = 0;
         window_size = 256;
         expected_q.delete();
         mismatches = 0;
      end else begin
         if (csr_we) window_size = csr_wdata;
         if (req_tvalid && req_tready)
            expected_q.push_back(run_request(req_tdata[0], req_tdata[3:1], req_tdata[11:4]));
         if (rsp_tvalid && rsp_tready) begin
            got = alloc_result_type'(rsp_tdata[17:0]);
            if (expected_q.size() == 0) begin
               $error("rsp transaction with no request outstanding");
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               if (got.ok !== want.ok) begin
                  $error("ok: expected %0d actual %0d", want.ok, got.ok);
                  mismatches++;
               end
               if (got.alloc_page !== want.alloc_page) begin
                  $error("alloc_page: expected %0d actual %0d", want.alloc_page,
                         got.alloc_page);
                  mismatches++;
               end
               if (got.free_count !== want.free_count) begin
                  $error("free_count: expected %0d actual %0d", want.free_count,
                         got.free_count);
                  mismatches++;
               end
            end
         end
      end
      errors <= mismatches + expected_q.size();
   end
endmodule

`default_nettype wire

// ===== tb/tb_buddy_page_allocator.sv =====
`default_nettype none

module tb_buddy_page_allocator
   import bpa_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // func, order, page
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // ok, alloc_page, free_count
   logic        csr_we;
   logic [8:0]  csr_wdata;   // window_pages
   int          errors;

   int          sent_count;
   int          done_count;
   int          max_gap;
   logic        long_hold;
   logic [3:0]  issued_q [$];   // {order, func} of each accepted request
   logic [10:0] live_blocks [$];   // {order, page} of blocks held by the host

   buddy_page_allocator u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   bpa_scoreboard u_scoreboard (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata), .errors(errors)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #60ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // track blocks granted to the host so later frees are well formed
   always @(posedge clock) begin
      logic [3:0] item;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            done_count++;
            item = issued_q.pop_front();
            if (item[0] == FuncAlloc && rsp_tdata[0])
               live_blocks.push_back({item[3:1], rsp_tdata[8:1]});
         end
         if (req_tvalid && req_tready) begin
            sent_count++;
            issued_q.push_back(req_tdata[3:0]);
         end
      end
   end

   // receiver with random stalls and one long hold-off on request
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            long_hold = 1'b0;
            rsp_tready <= 1'b1;
         end else begin
            n = (max_gap > 0) ? $urandom_range(0, 14) : 0;
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(negedge clock);
            end
            rsp_tready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   task automatic send_op(logic fn, logic [2:0] ord, logic [7:0] pg);
      int gap;
      gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, pg, ord, fn};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (done_count != sent_count || long_hold) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_window(logic [8:0] w);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= w;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic free_live();
      int idx;
      logic [10:0] blk;
      logic [7:0] low;
      idx = $urandom_range(0, live_blocks.size() - 1);
      blk = live_blocks[idx];
      live_blocks.delete(idx);
      // misaligned low bits are dropped by the block
      low = ($urandom_range(0, 3) == 0) ? 8'($urandom & ((1 << blk[10:8]) - 1)) : 8'd0;
      send_op(FuncFree, blk[10:8], blk[7:0] | low);
   endtask

   task automatic run_phase(int unsigned w, int items);
      int unsigned r;
      for (int unsigned p = 0; p < w && p < MaxPages; p += 64)
         send_op(FuncFree, 3'd6, 8'(p));
      repeat (items) begin
         r = $urandom_range(0, 99);
         if (r < 50)
            send_op(FuncAlloc, 3'($urandom_range(0, 6)), 8'($urandom));
         else if (r < 85 && live_blocks.size() > 0)
            free_live();
         else if (r < 92)
            send_op(FuncFree, 3'($urandom_range(0, 7)), 8'($urandom));
         else
            send_op(1'($urandom), 3'd7, 8'($urandom));
      end
   endtask

   initial begin
      sent_count = 0;
      done_count = 0;
      max_gap = 14;
      long_hold = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // directed: empty pool, bad order, carving, splits and merges
      send_op(FuncAlloc, 3'd0, 8'd0);
      send_op(FuncAlloc, 3'd7, 8'd0);
      send_op(FuncFree, 3'd7, 8'd255);
      send_op(FuncFree, 3'd6, 8'd0);
      send_op(FuncFree, 3'd6, 8'd64);
      send_op(FuncFree, 3'd6, 8'd128);
      send_op(FuncFree, 3'd6, 8'd255);
      send_op(FuncAlloc, 3'd0, 8'd255);
      send_op(FuncAlloc, 3'd1, 8'd0);
      send_op(FuncAlloc, 3'd6, 8'd0);
      send_op(FuncFree, 3'd0, 8'd0);
      send_op(FuncFree, 3'd1, 8'd3);
      send_op(FuncFree, 3'd1, 8'd3);
      send_op(FuncAlloc, 3'd6, 8'd0);
      send_op(FuncAlloc, 3'd6, 8'd0);
      send_op(FuncAlloc, 3'd6, 8'd0);
      send_op(FuncAlloc, 3'd6, 8'd0);
      send_op(FuncAlloc, 3'd6, 8'd0);
      send_op(FuncFree, 3'd0, 8'd255);
      set_window(9'd64);
      send_op(FuncFree, 3'd0, 8'd64);
      send_op(FuncFree, 3'd5, 8'd32);
      send_op(FuncAlloc, 3'd5, 8'd0);
      live_blocks.delete();

      run_phase(64, 80);
      set_window(9'd0);
      run_phase(0, 30);
      set_window(9'd192);
      long_hold = 1'b1;
      max_gap = 0;
      run_phase(192, 90);
      max_gap = 14;
      set_window(9'd300);
      run_phase(256, 110);
      set_window(9'd100);
      run_phase(64, 60);
      set_window(9'd511);
      max_gap = 0;
      run_phase(256, 90);
      max_gap = 14;
      set_window(9'd128);
      run_phase(128, 80);
      set_window(9'd256);
      run_phase(256, 110);

      drain();
      repeat (50) @(negedge clock);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

`default_nettype wire
